// ===== hdl/imu_dr_pkg.sv =====
// Shared types, constants and helpers for the IMU dead-reckoning step.
package imu_dr_pkg;

  localparam int COUNT_BITS = 8;
  localparam int ANGLE_BITS = 16;

  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [16:0] POLY_B = 17'd42048;
  localparam logic [16:0] POLY_C = 17'd4640;

  localparam int IN_BITS  = 240;
  localparam int OUT_BITS = 96;
  localparam int ADDR_BITS = 5;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_BIAS    = 3'd0;
  localparam logic [2:0] REG_JUMP    = 3'd1;
  localparam logic [2:0] REG_GRAVITY = 3'd2;
  localparam logic [2:0] REG_LIM_XY  = 3'd3;
  localparam logic [2:0] REG_LIM_Z   = 3'd4;
  localparam logic [2:0] REG_PERIOD  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AXIS_AT,
    ST_AXIS_HALF,
    ST_AXIS_VT,
    ST_SIN_X2,
    ST_SIN_C,
    ST_SIN_B,
    ST_SIN_A,
    ST_MAT,
    ST_ROT,
    ST_FINAL,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MODE_SET,
    MODE_ADD,
    MODE_SUB
  } mat_mode_e;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hdl/imu_dead_reckoning_step.sv =====
// Top level of the IMU strapdown dead-reckoning step with still-axis clearing.
//
// One item (three Q16.16 accelerations, yaw/pitch/roll binary angles and a corrected
// pose) goes in; one item (composed position, increment plus previous increment)
// comes out. All arithmetic runs through one shared 34 x 20 bit signed multiplier
// under a small sequencer, each multiply using two phases (operand and product
// register, then write-back). The steps in order are the three axis updates, six
// sine/cosine evaluations, the rotation matrix, the matrix-vector product and the
// output composition. The input side stays not ready until the result is taken and
// the sequencer is back in idle, so a new item is accepted only after the previous
// result has been taken.
// Configuration sits on an APB-style port, register i at byte address 4*i; write
// it only while the block is idle.
module imu_dead_reckoning_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // accel_x, accel_y, accel_z, yaw_angle, pitch_angle, roll_angle, pose_x,
  // pose_y, pose_z (from bit 0 up)
  input  logic [imu_dr_pkg::IN_BITS-1:0]    s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // out_x, out_y, out_z (from bit 0 up)
  output logic [imu_dr_pkg::OUT_BITS-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [imu_dr_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int FB = imu_dr_pkg::ANGLE_BITS - 2;
  localparam int CB = imu_dr_pkg::COUNT_BITS;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};
  localparam logic [imu_dr_pkg::ANGLE_BITS-1:0] QUARTER =
    imu_dr_pkg::ANGLE_BITS'(1) << FB;

  // Matrix operand sources
  localparam logic [2:0] SRC_SY = 3'd0;
  localparam logic [2:0] SRC_CY = 3'd1;
  localparam logic [2:0] SRC_SP = 3'd2;
  localparam logic [2:0] SRC_CP = 3'd3;
  localparam logic [2:0] SRC_SR = 3'd4;
  localparam logic [2:0] SRC_CR = 3'd5;
  localparam logic [2:0] SRC_P0 = 3'd6;
  localparam logic [2:0] SRC_P1 = 3'd7;
  // Destinations 0..8 are matrix entries, then the two partial products
  localparam logic [3:0] DST_P0 = 4'd9;
  localparam logic [3:0] DST_P1 = 4'd10;

  // ---------------------------------------------------------------- config
  logic [16:0] bias_q;
  logic [30:0] jump_q;
  logic [20:0] grav_q;
  logic [7:0]  lim_xy_q;
  logic [7:0]  lim_z_q;
  logic [16:0] period_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q   <= 17'd655;
      jump_q   <= 31'd32768;
      grav_q   <= 21'd642908;
      lim_xy_q <= 8'd20;
      lim_z_q  <= 8'd15;
      period_q <= 17'd2185;
    end else if (cfg_wr) begin
      case (reg_idx)
        imu_dr_pkg::REG_BIAS:    bias_q   <= pwdata[16:0];
        imu_dr_pkg::REG_JUMP:    jump_q   <= pwdata[30:0];
        imu_dr_pkg::REG_GRAVITY: grav_q   <= pwdata[20:0];
        imu_dr_pkg::REG_LIM_XY:  lim_xy_q <= pwdata[7:0];
        imu_dr_pkg::REG_LIM_Z:   lim_z_q  <= pwdata[7:0];
        imu_dr_pkg::REG_PERIOD:  period_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      imu_dr_pkg::REG_BIAS:    prdata = {15'd0, bias_q};
      imu_dr_pkg::REG_JUMP:    prdata = {1'b0, jump_q};
      imu_dr_pkg::REG_GRAVITY: prdata = {11'd0, grav_q};
      imu_dr_pkg::REG_LIM_XY:  prdata = {24'd0, lim_xy_q};
      imu_dr_pkg::REG_LIM_Z:   prdata = {24'd0, lim_z_q};
      imu_dr_pkg::REG_PERIOD:  prdata = {15'd0, period_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- control
  imu_dr_pkg::state_e state_q, state_d;
  logic       phase_q, phase_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] col_q, col_d;
  logic       in_acc;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Next state: every multiply state spends phase 0 forming the product and
  // phase 1 writing it back.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    col_d   = col_q;
    case (state_q)
      imu_dr_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = imu_dr_pkg::ST_AXIS_AT;
          phase_d = 1'b0;
          cnt_d   = 4'd0;
          col_d   = 2'd0;
        end
      end
      imu_dr_pkg::ST_FINAL: state_d = imu_dr_pkg::ST_OUT;
      imu_dr_pkg::ST_OUT: begin
        if (m_axis_tready_i) state_d = imu_dr_pkg::ST_IDLE;
      end
      default: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          case (state_q)
            imu_dr_pkg::ST_AXIS_AT:   state_d = imu_dr_pkg::ST_AXIS_HALF;
            imu_dr_pkg::ST_AXIS_HALF: state_d = imu_dr_pkg::ST_AXIS_VT;
            imu_dr_pkg::ST_AXIS_VT: begin
              if (cnt_q == 4'd2) begin
                state_d = imu_dr_pkg::ST_SIN_X2;
                cnt_d   = 4'd0;
              end else begin
                state_d = imu_dr_pkg::ST_AXIS_AT;
                cnt_d   = cnt_q + 4'd1;
              end
            end
            imu_dr_pkg::ST_SIN_X2: state_d = imu_dr_pkg::ST_SIN_C;
            imu_dr_pkg::ST_SIN_C:  state_d = imu_dr_pkg::ST_SIN_B;
            imu_dr_pkg::ST_SIN_B:  state_d = imu_dr_pkg::ST_SIN_A;
            imu_dr_pkg::ST_SIN_A: begin
              if (cnt_q == 4'd5) begin
                state_d = imu_dr_pkg::ST_MAT;
                cnt_d   = 4'd0;
              end else begin
                state_d = imu_dr_pkg::ST_SIN_X2;
                cnt_d   = cnt_q + 4'd1;
              end
            end
            imu_dr_pkg::ST_MAT: begin
              if (cnt_q == 4'd13) begin
                state_d = imu_dr_pkg::ST_ROT;
                cnt_d   = 4'd0;
                col_d   = 2'd0;
              end else begin
                cnt_d = cnt_q + 4'd1;
              end
            end
            imu_dr_pkg::ST_ROT: begin
              if (col_q == 2'd2) begin
                col_d = 2'd0;
                if (cnt_q == 4'd2) state_d = imu_dr_pkg::ST_FINAL;
                else cnt_d = cnt_q + 4'd1;
              end else begin
                col_d = col_q + 2'd1;
              end
            end
            default: state_d = imu_dr_pkg::ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imu_dr_pkg::ST_IDLE;
      phase_q <= 1'b0;
      cnt_q   <= 4'd0;
      col_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready_o = (state_q == imu_dr_pkg::ST_IDLE);
    m_axis_tvalid_o = (state_q == imu_dr_pkg::ST_OUT);
  end

  // ---------------------------------------------------------------- datapath
  logic [imu_dr_pkg::IN_BITS-1:0] in_q;
  logic signed [31:0] acc_q   [3];
  logic signed [31:0] vel_q   [3];
  logic signed [31:0] kept_q  [3];
  logic [CB-1:0]      still_q [3];
  logic signed [31:0] prev_q  [3];
  logic signed [31:0] lin_q   [3];
  logic signed [31:0] inc_q   [3];
  logic signed [31:0] out_q   [3];
  logic signed [32:0] at_q;
  logic signed [31:0] half_q;
  logic [16:0]        x_q;
  logic [16:0]        x2_q;
  logic [16:0]        t_q;
  logic               neg_q;
  logic signed [17:0] sc_q [6];
  logic signed [17:0] p_q  [2];
  logic signed [19:0] r_q  [9];
  logic signed [53:0] s_q;
  logic signed [53:0] prod_q;

  logic signed [33:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [37:0] res16;
  logic [1:0]         ax;
  logic [1:0]         ang_sel;

  assign ax      = cnt_q[1:0];
  assign ang_sel = cnt_q[2:1];
  assign res16   = prod_q[53:16];

  // Sine argument: fold the angle into a quarter-wave abscissa
  logic [15:0]                         ang16;
  logic signed [31:0]                  ang32;
  logic [imu_dr_pkg::ANGLE_BITS-1:0]   ang;
  logic [1:0]                          quad;
  logic [FB+15:0]                      x_wide;
  logic [16:0]                         x_raw;
  logic [16:0]                         x_now;

  always_comb begin
    case (ang_sel)
      2'd0:    ang16 = in_q[111:96];
      2'd1:    ang16 = in_q[127:112];
      default: ang16 = in_q[143:128];
    endcase
    ang32  = 32'($signed(ang16));
    ang    = ang32[imu_dr_pkg::ANGLE_BITS-1:0] + (cnt_q[0] ? QUARTER : '0);
    quad   = ang[imu_dr_pkg::ANGLE_BITS-1 -: 2];
    x_wide = {ang[FB-1:0], 16'd0} >> FB;
    x_raw  = x_wide[16:0];
    x_now  = quad[0] ? (17'd65536 - x_raw) : x_raw;
  end

  // Matrix micro-op table
  logic [2:0]             mat_a_sel, mat_b_sel;
  logic [3:0]             mat_dst;
  imu_dr_pkg::mat_mode_e  mat_mode;
  logic signed [17:0]     mat_a, mat_b;

  always_comb begin
    mat_a_sel = SRC_CY;
    mat_b_sel = SRC_CP;
    mat_dst   = 4'd0;
    mat_mode  = imu_dr_pkg::MODE_SET;
    case (cnt_q)
      4'd0:  begin mat_a_sel = SRC_CY; mat_b_sel = SRC_CP; mat_dst = 4'd0; end
      4'd1:  begin mat_a_sel = SRC_CY; mat_b_sel = SRC_SP; mat_dst = DST_P0; end
      4'd2:  begin mat_a_sel = SRC_SY; mat_b_sel = SRC_SP; mat_dst = DST_P1; end
      4'd3:  begin mat_a_sel = SRC_P0; mat_b_sel = SRC_SR; mat_dst = 4'd1; end
      4'd4:  begin
        mat_a_sel = SRC_SY; mat_b_sel = SRC_CR; mat_dst = 4'd1;
        mat_mode = imu_dr_pkg::MODE_SUB;
      end
      4'd5:  begin mat_a_sel = SRC_P0; mat_b_sel = SRC_CR; mat_dst = 4'd2; end
      4'd6:  begin
        mat_a_sel = SRC_SY; mat_b_sel = SRC_SR; mat_dst = 4'd2;
        mat_mode = imu_dr_pkg::MODE_ADD;
      end
      4'd7:  begin mat_a_sel = SRC_SY; mat_b_sel = SRC_CP; mat_dst = 4'd3; end
      4'd8:  begin mat_a_sel = SRC_P1; mat_b_sel = SRC_SR; mat_dst = 4'd4; end
      4'd9:  begin
        mat_a_sel = SRC_CY; mat_b_sel = SRC_CR; mat_dst = 4'd4;
        mat_mode = imu_dr_pkg::MODE_ADD;
      end
      4'd10: begin mat_a_sel = SRC_P1; mat_b_sel = SRC_CR; mat_dst = 4'd5; end
      4'd11: begin
        mat_a_sel = SRC_CY; mat_b_sel = SRC_SR; mat_dst = 4'd5;
        mat_mode = imu_dr_pkg::MODE_SUB;
      end
      4'd12: begin mat_a_sel = SRC_CP; mat_b_sel = SRC_SR; mat_dst = 4'd7; end
      4'd13: begin mat_a_sel = SRC_CP; mat_b_sel = SRC_CR; mat_dst = 4'd8; end
      default: ;
    endcase
    case (mat_a_sel)
      SRC_P0:  mat_a = p_q[0];
      SRC_P1:  mat_a = p_q[1];
      default: mat_a = sc_q[mat_a_sel];
    endcase
    case (mat_b_sel)
      SRC_P0:  mat_b = p_q[0];
      SRC_P1:  mat_b = p_q[1];
      default: mat_b = sc_q[mat_b_sel];
    endcase
  end

  // Shared multiplier operands
  logic [3:0] r_idx;
  always_comb begin
    r_idx = 4'(cnt_q[1:0]) * 4'd3 + 4'(col_q);
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      imu_dr_pkg::ST_AXIS_AT: begin
        mul_a = 34'(acc_q[ax]);
        mul_b = 20'($signed({1'b0, period_q}));
      end
      imu_dr_pkg::ST_AXIS_HALF: begin
        mul_a = 34'(at_q);
        mul_b = 20'($signed({1'b0, period_q}));
      end
      imu_dr_pkg::ST_AXIS_VT: begin
        mul_a = 34'(vel_q[ax]);
        mul_b = 20'($signed({1'b0, period_q}));
      end
      imu_dr_pkg::ST_SIN_X2: begin
        mul_a = 34'({1'b0, x_now});
        mul_b = 20'({1'b0, x_now});
      end
      imu_dr_pkg::ST_SIN_C: begin
        mul_a = 34'({1'b0, imu_dr_pkg::POLY_C});
        mul_b = 20'({1'b0, x2_q});
      end
      imu_dr_pkg::ST_SIN_B: begin
        mul_a = 34'({1'b0, t_q});
        mul_b = 20'({1'b0, x2_q});
      end
      imu_dr_pkg::ST_SIN_A: begin
        mul_a = 34'({1'b0, t_q});
        mul_b = 20'({1'b0, x_q});
      end
      imu_dr_pkg::ST_MAT: begin
        mul_a = 34'(mat_a);
        mul_b = 20'(mat_b);
      end
      imu_dr_pkg::ST_ROT: begin
        mul_a = 34'(lin_q[col_q]);
        mul_b = r_q[r_idx];
      end
      default: ;
    endcase
  end

  // Axis update: keep test, velocity, still counter
  logic signed [32:0] diff;
  logic [32:0]        abs_diff;
  logic               a_gt_bias;
  logic               keep;
  logic signed [38:0] vel_sum;
  logic [CB-1:0]      still_nx;
  logic [7:0]         lim;
  logic signed [31:0] vel_nx;
  logic signed [34:0] lin_sum;
  logic signed [53:0] s_nx;
  logic signed [37:0] s16;
  logic signed [38:0] pose_sum;
  logic signed [31:0] pose_v;
  logic signed [19:0] mat_val;
  logic signed [19:0] mat_nx;

  always_comb begin
    diff      = 33'(kept_q[ax]) - 33'(acc_q[ax]);
    abs_diff  = diff[32] ? 33'(-diff) : 33'(diff);
    a_gt_bias = !acc_q[ax][31] && (acc_q[ax][30:0] > 31'(bias_q));
    keep      = a_gt_bias && (abs_diff < 33'(jump_q));
    vel_sum   = 39'(vel_q[ax]) + 39'(res16);
    lim       = (ax == 2'd2) ? lim_z_q : lim_xy_q;
    if (keep) still_nx = '0;
    else if (still_q[ax] != CMAX) still_nx = still_q[ax] + CB'(1);
    else still_nx = still_q[ax];
    vel_nx = keep ? imu_dr_pkg::sat32(64'(vel_sum)) : vel_q[ax];
    if (17'(still_nx) > 17'(lim)) vel_nx = '0;
    lin_sum  = 35'($signed(res16[33:0])) + 35'(half_q);
    s_nx     = ((col_q == 2'd0) ? 54'sd0 : s_q) + prod_q;
    s16      = s_nx[53:16];
    case (cnt_q[1:0])
      2'd0:    pose_v = in_q[175:144];
      2'd1:    pose_v = in_q[207:176];
      default: pose_v = in_q[239:208];
    endcase
    pose_sum = 39'(pose_v) + 39'(s16);
    mat_val  = res16[19:0];
    case (mat_mode)
      imu_dr_pkg::MODE_ADD: mat_nx = r_q[mat_dst] + mat_val;
      imu_dr_pkg::MODE_SUB: mat_nx = r_q[mat_dst] - mat_val;
      default:              mat_nx = mat_val;
    endcase
  end

  // State that the reset clears
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vel_q[i]   <= '0;
        kept_q[i]  <= '0;
        still_q[i] <= '0;
        prev_q[i]  <= '0;
      end
    end else if (state_q == imu_dr_pkg::ST_AXIS_AT && phase_q) begin
      vel_q[ax]   <= vel_nx;
      kept_q[ax]  <= keep ? acc_q[ax] : 32'sd0;
      still_q[ax] <= still_nx;
    end else if (state_q == imu_dr_pkg::ST_FINAL) begin
      for (int i = 0; i < 3; i++) prev_q[i] <= inc_q[i];
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (!phase_q) prod_q <= mul_a * mul_b;
    if (in_acc) begin
      in_q     <= s_axis_tdata_i;
      acc_q[0] <= s_axis_tdata_i[31:0];
      acc_q[1] <= s_axis_tdata_i[63:32];
      // Take gravity off z at the door
      acc_q[2] <= imu_dr_pkg::sat32(64'($signed(s_axis_tdata_i[95:64])) -
                                    64'($signed({43'd0, grav_q})));
    end
    case (state_q)
      imu_dr_pkg::ST_AXIS_AT:
        if (phase_q) at_q <= keep ? res16[32:0] : 33'sd0;
      imu_dr_pkg::ST_AXIS_HALF:
        if (phase_q) half_q <= prod_q[48:17];
      imu_dr_pkg::ST_AXIS_VT:
        if (phase_q) lin_q[ax] <= imu_dr_pkg::sat32(64'(lin_sum));
      imu_dr_pkg::ST_SIN_X2: begin
        if (!phase_q) begin
          x_q   <= x_now;
          neg_q <= quad[1];
        end else begin
          x2_q <= res16[16:0];
        end
      end
      imu_dr_pkg::ST_SIN_C:
        if (phase_q) t_q <= imu_dr_pkg::POLY_B - res16[16:0];
      imu_dr_pkg::ST_SIN_B:
        if (phase_q) t_q <= imu_dr_pkg::POLY_A - res16[16:0];
      imu_dr_pkg::ST_SIN_A:
        if (phase_q) sc_q[cnt_q[2:0]] <= neg_q ? -res16[17:0] : res16[17:0];
      imu_dr_pkg::ST_MAT: begin
        if (phase_q) begin
          if (mat_dst == DST_P0) p_q[0] <= res16[17:0];
          else if (mat_dst == DST_P1) p_q[1] <= res16[17:0];
          else r_q[mat_dst] <= mat_nx;
          // Bottom-left entry is just minus sine of pitch
          if (cnt_q == 4'd0) r_q[6] <= -20'(sc_q[SRC_SP]);
        end
      end
      imu_dr_pkg::ST_ROT: begin
        if (phase_q) begin
          s_q <= s_nx;
          if (col_q == 2'd2) inc_q[cnt_q[1:0]] <= imu_dr_pkg::sat32(64'(pose_sum));
        end
      end
      imu_dr_pkg::ST_FINAL: begin
        for (int i = 0; i < 3; i++)
          out_q[i] <= imu_dr_pkg::sat32(64'(inc_q[i]) + 64'(prev_q[i]));
      end
      default: ;
    endcase
  end

  assign m_axis_tdata_o = {out_q[2], out_q[1], out_q[0]};

endmodule

// ===== hdl/imu_dr_checker.sv =====
// Port-level checks for the IMU dead-reckoning step, bound to the top level.
module imu_dr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [imu_dr_pkg::OUT_BITS-1:0]  m_axis_tdata_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i
);

  // Hold a stalled result steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Never take an item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("ready while result pending");

  // Drop ready straight after an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o && !m_axis_tvalid_o)
    else $error("busy not held after accept");

  // Return to ready once the result is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=> s_axis_tready_o && !m_axis_tvalid_o)
    else $error("not ready after result taken");

endmodule

bind imu_dead_reckoning_step imu_dr_checker u_imu_dr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);
